@@ hw/rtl/stunp_pkg.sv @@
package stunp_pkg;

  // Datagram offset counter width; saturates at its all-ones value.
  localparam int OFFSET_BITS = 17;

  localparam int HDR_BYTES    = 20;
  localparam int LEN_FIRST    = 2;
  localparam int COOKIE_FIRST = 4;
  localparam int TXID_FIRST   = 8;

  localparam logic [31:0] COOKIE_RESET = 32'h2112A442;

  // Result queue sizing.
  localparam int MAX_PUSH       = 3;
  localparam int PUSH_CNT_BITS  = $clog2(MAX_PUSH + 1);
  localparam int QUEUE_DEPTH    = 8;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [OFFSET_BITS-1:0] offset_t;

  typedef enum logic [2:0] {
    KIND_TXID        = 3'd0,
    KIND_HEADER_DONE = 3'd1,
    KIND_ATTR_HDR    = 3'd2,
    KIND_ATTR_VALUE  = 3'd3,
    KIND_ATTR_DONE   = 3'd4,
    KIND_END         = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_TOO_SHORT  = 2'd1,
    STATUS_BAD_COOKIE = 2'd2,
    STATUS_SHORT_MSG  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ATTR_HDR = 3'd1,
    PH_ATTR_VAL = 3'd2,
    PH_PAD      = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } in_beat_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] message_type;
    logic [15:0] declared_length;
    logic [15:0] attribute_type;
    logic [15:0] attribute_length;
    logic [7:0]  out_byte;
    logic [15:0] byte_position;
    status_t     status;
    logic        last_result;
  } result_t;

  typedef logic [PUSH_CNT_BITS-1:0] push_cnt_t;

  // Results produced by one accepted byte, packed in order.
  typedef struct packed {
    push_cnt_t                   count;
    result_t [MAX_PUSH-1:0]      item;
  } push_t;

endpackage

@@ hw/rtl/stun_message_parser_top.sv @@
// Channel   | Dir | Handshake                 | Beat
// ----------+-----+---------------------------+----------------------------------------
// byte      | in  | byte_valid / byte_stall   | byte_data: one datagram byte + end flag
// result    | out | result_valid/result_stall | result: one parse result
// cookie    | in  | cookie_we                 | cookie_wdata: expected magic cookie
//
// One byte beat is taken per cycle while byte_stall is low; the parse state updates
// at that edge and the up to three results it causes land in an 8-entry result queue.
// Output drains one result per cycle from the queue head (registered) when not stalled.
// byte_stall rises when the queue has fewer than three free entries, so a
// downstream stall backs up into the byte side once the queue fills.
// The results of a byte beat enter the queue at the edge that takes the byte.
// Reset (rst, synchronous): clears parse state and queue, cookie back to 0x2112A442.
module stun_message_parser_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  stunp_pkg::in_beat_t byte_data,
  output logic                result_valid,
  input  logic                result_stall,
  output stunp_pkg::result_t  result,
  input  logic                cookie_we,
  input  logic [31:0]         cookie_wdata
);

  logic [31:0]      cookie_reg;
  logic             byte_accept;
  stunp_pkg::push_t push;

  // Expected cookie; write only while the parser is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cookie_reg <= stunp_pkg::COOKIE_RESET;
    end else if (cookie_we) begin
      cookie_reg <= cookie_wdata;
    end
  end

  assign byte_accept = byte_valid && !byte_stall;

  // Header check, txid emission and attribute walk.
  stunp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (byte_accept),
    .data         (byte_data),
    .magic_cookie (cookie_reg),
    .push         (push)
  );

  // Result queue: multi-push, single-pop, parts the two sides.
  stunp_result_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (byte_stall),
    .valid (result_valid),
    .stall (result_stall),
    .head  (result)
  );

endmodule

@@ hw/rtl/stunp_parser.sv @@
module stunp_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  stunp_pkg::in_beat_t   data,
  input  logic [31:0]           magic_cookie,
  output stunp_pkg::push_t      push
);

  localparam stunp_pkg::offset_t OFFSET_MAX = '1;

  stunp_pkg::offset_t byte_offset, byte_offset_next;
  stunp_pkg::phase_t  parse_phase, parse_phase_next;
  logic [31:0]        cookie_shift, cookie_shift_next;
  logic               cookie_ok, cookie_ok_next;
  logic [15:0]        saved_message_type, saved_message_type_next;
  logic [15:0]        saved_declared_length, saved_declared_length_next;
  logic [15:0]        current_attr_type, current_attr_type_next;
  logic [15:0]        current_attr_length, current_attr_length_next;
  logic [15:0]        value_bytes_seen, value_bytes_seen_next;

  stunp_pkg::offset_t next_offset;
  stunp_pkg::offset_t decl_end;
  stunp_pkg::offset_t txid_pos;
  stunp_pkg::phase_t  next_attr;
  logic [15:0]        vbs_inc;
  logic [15:0]        new_len;
  logic [7:0]         b;

  stunp_pkg::result_t res_a, res_b, res_c;
  logic               a_v, b_v, c_v;

  function automatic stunp_pkg::result_t attr_res(stunp_pkg::kind_t k, logic [15:0] t,
                                                  logic [15:0] l);
    stunp_pkg::result_t r;
    r                  = '0;
    r.kind             = k;
    r.attribute_type   = t;
    r.attribute_length = l;
    return r;
  endfunction

  assign b           = data.data_byte;
  assign next_offset = (byte_offset == OFFSET_MAX) ? byte_offset
                                                   : byte_offset + stunp_pkg::offset_t'(1);
  assign decl_end    = stunp_pkg::offset_t'(stunp_pkg::HDR_BYTES)
                     + stunp_pkg::offset_t'(saved_declared_length);
  assign next_attr   = (next_offset < decl_end) ? stunp_pkg::PH_ATTR_HDR : stunp_pkg::PH_DONE;
  assign txid_pos    = byte_offset - stunp_pkg::offset_t'(stunp_pkg::TXID_FIRST);
  assign vbs_inc     = value_bytes_seen + 16'd1;
  assign new_len     = {current_attr_length[15:8], b};

  always_comb begin
    byte_offset_next           = next_offset;
    parse_phase_next           = parse_phase;
    cookie_shift_next          = cookie_shift;
    cookie_ok_next             = cookie_ok;
    saved_message_type_next    = saved_message_type;
    saved_declared_length_next = saved_declared_length;
    current_attr_type_next     = current_attr_type;
    current_attr_length_next   = current_attr_length;
    value_bytes_seen_next      = value_bytes_seen;
    res_a = '0;
    res_b = '0;
    res_c = '0;
    a_v   = 1'b0;
    b_v   = 1'b0;
    c_v   = 1'b0;

    unique case (parse_phase)
      stunp_pkg::PH_HEADER: begin
        if (byte_offset < stunp_pkg::offset_t'(stunp_pkg::LEN_FIRST)) begin
          saved_message_type_next = {saved_message_type[7:0], b};
        end else if (byte_offset < stunp_pkg::offset_t'(stunp_pkg::COOKIE_FIRST)) begin
          saved_declared_length_next = {saved_declared_length[7:0], b};
        end else if (byte_offset < stunp_pkg::offset_t'(stunp_pkg::TXID_FIRST)) begin
          cookie_shift_next = {cookie_shift[23:0], b};
          if (byte_offset == stunp_pkg::offset_t'(stunp_pkg::TXID_FIRST - 1)) begin
            cookie_ok_next = ({cookie_shift[23:0], b} == magic_cookie);
          end
        end else if (cookie_ok) begin
          a_v                 = 1'b1;
          res_a.kind          = stunp_pkg::KIND_TXID;
          res_a.out_byte      = b;
          res_a.byte_position = txid_pos[15:0];
        end
        if (byte_offset == stunp_pkg::offset_t'(stunp_pkg::HDR_BYTES - 1)) begin
          if (cookie_ok) begin
            b_v                   = 1'b1;
            res_b.kind            = stunp_pkg::KIND_HEADER_DONE;
            res_b.message_type    = saved_message_type;
            res_b.declared_length = saved_declared_length;
            parse_phase_next = (saved_declared_length != 16'd0) ? stunp_pkg::PH_ATTR_HDR
                                                                : stunp_pkg::PH_DONE;
          end else begin
            parse_phase_next = stunp_pkg::PH_DONE;
          end
        end
      end
      stunp_pkg::PH_ATTR_HDR: begin
        unique case (byte_offset[1:0])
          2'd0: current_attr_type_next = {b, 8'h00};
          2'd1: current_attr_type_next = {current_attr_type[15:8], b};
          2'd2: current_attr_length_next = {b, 8'h00};
          2'd3: begin
            current_attr_length_next = new_len;
            value_bytes_seen_next    = 16'd0;
            a_v   = 1'b1;
            res_a = attr_res(stunp_pkg::KIND_ATTR_HDR, current_attr_type, new_len);
            if (new_len == 16'd0) begin
              b_v   = 1'b1;
              res_b = attr_res(stunp_pkg::KIND_ATTR_DONE, current_attr_type, new_len);
              parse_phase_next = next_attr;
            end else begin
              parse_phase_next = stunp_pkg::PH_ATTR_VAL;
            end
          end
          default: ;
        endcase
      end
      stunp_pkg::PH_ATTR_VAL: begin
        a_v   = 1'b1;
        res_a = attr_res(stunp_pkg::KIND_ATTR_VALUE, current_attr_type, current_attr_length);
        res_a.out_byte      = b;
        res_a.byte_position = value_bytes_seen;
        value_bytes_seen_next = vbs_inc;
        if (vbs_inc == current_attr_length) begin
          b_v   = 1'b1;
          res_b = attr_res(stunp_pkg::KIND_ATTR_DONE, current_attr_type, current_attr_length);
          parse_phase_next = (current_attr_length[1:0] == 2'd0) ? next_attr
                                                                : stunp_pkg::PH_PAD;
        end
      end
      stunp_pkg::PH_PAD: begin
        value_bytes_seen_next = vbs_inc;
        if (vbs_inc[1:0] == 2'd0) begin
          parse_phase_next = next_attr;
        end
      end
      default: ;
    endcase

    if (data.end_of_datagram) begin
      c_v               = 1'b1;
      res_c.kind        = stunp_pkg::KIND_END;
      res_c.last_result = 1'b1;
      // size < 20 is offset < 19; size < 20 + length is offset < 19 + length
      if (byte_offset < stunp_pkg::offset_t'(stunp_pkg::HDR_BYTES - 1)) begin
        res_c.status = stunp_pkg::STATUS_TOO_SHORT;
      end else if (!cookie_ok_next) begin
        res_c.status = stunp_pkg::STATUS_BAD_COOKIE;
      end else if (byte_offset < decl_end - stunp_pkg::offset_t'(1)) begin
        res_c.status = stunp_pkg::STATUS_SHORT_MSG;
      end else begin
        res_c.status = stunp_pkg::STATUS_OK;
      end
      byte_offset_next           = '0;
      parse_phase_next           = stunp_pkg::PH_HEADER;
      cookie_shift_next          = '0;
      cookie_ok_next             = 1'b1;
      saved_message_type_next    = '0;
      saved_declared_length_next = '0;
      current_attr_type_next     = '0;
      current_attr_length_next   = '0;
      value_bytes_seen_next      = '0;
    end
  end

  // Pack: the second slot only ever appears with the first.
  always_comb begin
    push.count   = stunp_pkg::push_cnt_t'({1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v});
    push.item[0] = a_v ? res_a : res_c;
    push.item[1] = b_v ? res_b : res_c;
    push.item[2] = res_c;
    if (!accept) begin
      push.count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset           <= '0;
      parse_phase           <= stunp_pkg::PH_HEADER;
      cookie_shift          <= '0;
      cookie_ok             <= 1'b1;
      saved_message_type    <= '0;
      saved_declared_length <= '0;
      current_attr_type     <= '0;
      current_attr_length   <= '0;
      value_bytes_seen      <= '0;
    end else if (accept) begin
      byte_offset           <= byte_offset_next;
      parse_phase           <= parse_phase_next;
      cookie_shift          <= cookie_shift_next;
      cookie_ok             <= cookie_ok_next;
      saved_message_type    <= saved_message_type_next;
      saved_declared_length <= saved_declared_length_next;
      current_attr_type     <= current_attr_type_next;
      current_attr_length   <= current_attr_length_next;
      value_bytes_seen      <= value_bytes_seen_next;
    end
  end

endmodule

@@ hw/rtl/stunp_result_queue.sv @@
module stunp_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  stunp_pkg::push_t    push,
  output logic                full,
  output logic                valid,
  input  logic                stall,
  output stunp_pkg::result_t  head
);

  stunp_pkg::result_t entries [stunp_pkg::QUEUE_DEPTH];

  logic [stunp_pkg::QUEUE_PTR_BITS-1:0] wr_ptr, wr_ptr_next;
  logic [stunp_pkg::QUEUE_PTR_BITS-1:0] rd_ptr, rd_ptr_next;
  logic [stunp_pkg::QUEUE_CNT_BITS-1:0] count, count_next;
  logic                                 pop;

  assign valid = (count != '0);
  assign head  = entries[rd_ptr];
  assign pop   = valid && !stall;
  // Room for a worst-case byte must be there before it is taken.
  assign full  = count > stunp_pkg::QUEUE_CNT_BITS'(stunp_pkg::QUEUE_DEPTH - stunp_pkg::MAX_PUSH);

  assign wr_ptr_next = wr_ptr + stunp_pkg::QUEUE_PTR_BITS'(push.count);
  assign rd_ptr_next = rd_ptr + stunp_pkg::QUEUE_PTR_BITS'(pop);
  assign count_next  = count + stunp_pkg::QUEUE_CNT_BITS'(push.count)
                     - stunp_pkg::QUEUE_CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < stunp_pkg::MAX_PUSH; i++) begin
      if (stunp_pkg::push_cnt_t'(i) < push.count) begin
        entries[wr_ptr + stunp_pkg::QUEUE_PTR_BITS'(i)] <= push.item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

@@ hw/rtl/stunp_checker.sv @@
module stunp_checker (
  input logic                clk,
  input logic                rst,
  input logic                byte_valid,
  input logic                byte_stall,
  input stunp_pkg::in_beat_t byte_data,
  input logic                result_valid,
  input logic                result_stall,
  input stunp_pkg::result_t  result
);

  // Stalled result beat holds.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  // The final byte of a datagram always leaves its status queued.
  assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && byte_data.end_of_datagram |=> result_valid)
    else $error("no result after end of datagram");

  // An empty queue never holds off the byte side.
  assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !byte_stall)
    else $error("byte side stalled with empty queue");

  // Reset empties the queue.
  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result present after reset");

endmodule

bind stun_message_parser_top stunp_checker u_stunp_checker (.*);
